### rtl/core/lmae_pkg.sv
// package for the led matrix animation engine: payload types, codes and pattern tables
`default_nettype none

package lmae_pkg;

  // action codes
  localparam logic [1:0] ActTick    = 2'd0;
  localparam logic [1:0] ActCommand = 2'd1;
  localparam logic [1:0] ActQuery   = 2'd2;
  localparam logic [1:0] ActStop    = 2'd3;

  // light mode codes
  localparam logic [7:0] ModeNone    = 8'd0;
  localparam logic [7:0] ModeText    = 8'd1;
  localparam logic [7:0] ModeFlash   = 8'd2;
  localparam logic [7:0] ModeRandom  = 8'd3;
  localparam logic [7:0] ModeRipple  = 8'd4;
  localparam logic [7:0] ModeSpiral  = 8'd5;
  localparam logic [7:0] ModeChecker = 8'd6;
  localparam logic [7:0] ModeStop    = 8'd254;

  localparam int unsigned NumPixels = 25;

  localparam logic [24:0] AllPixels  = 25'h1FFFFFF;
  localparam logic [24:0] EvenPixels = 25'h1555555;
  localparam logic [24:0] OddPixels  = 25'h0AAAAAA;

  // dwell times in ms
  localparam logic [9:0] DwellDefault = 10'd1000;
  localparam logic [9:0] DwellRandom  = 10'd100;
  localparam logic [9:0] DwellRipple  = 10'd400;
  localparam logic [9:0] DwellSpiral  = 10'd50;
  localparam logic [9:0] DwellReset   = 10'd100;

  // spiral and ripple index bounds where the walk turns around
  localparam logic [4:0] SpiralTop    = 5'd25;
  localparam logic [4:0] SpiralBottom = 5'd31;
  localparam logic [4:0] RippleTop    = 5'd3;
  localparam logic [4:0] RippleBottom = 5'd0;

  localparam logic [15:0] StopReport = {ModeStop, ModeStop};

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] light_select;
    logic [7:0] audio_select;
    logic [4:0] random_pixel_a;
    logic [4:0] random_pixel_b;
    logic [4:0] random_pixel_c;
    logic [4:0] random_pixel_d;
  } lmae_in_t;

  typedef struct packed {
    logic        frame_valid;
    logic [24:0] frame_bits;
    logic [9:0]  dwell_ms;
    logic        report_valid;
    logic [15:0] report_word;
    logic        display_active;
  } lmae_out_t;

  // rings of the ripple, centre outward
  function automatic logic [24:0] ring_mask(input logic [1:0] ring);
    logic [24:0] m;
    case (ring)
      2'd0:    m = 25'h0000000;
      2'd1:    m = 25'h0001000;
      2'd2:    m = 25'h00729C0;
      default: m = 25'h1F8C63F;
    endcase
    return m;
  endfunction

  // one-hot pixel for a spiral position, zero beyond the last pixel
  function automatic logic [24:0] coil_bit(input logic [4:0] pos);
    logic [4:0] px;
    logic       hit;
    hit = 1'b1;
    case (pos)
      5'd0:  px = 5'd12;
      5'd1:  px = 5'd13;
      5'd2:  px = 5'd8;
      5'd3:  px = 5'd7;
      5'd4:  px = 5'd6;
      5'd5:  px = 5'd11;
      5'd6:  px = 5'd16;
      5'd7:  px = 5'd17;
      5'd8:  px = 5'd18;
      5'd9:  px = 5'd19;
      5'd10: px = 5'd14;
      5'd11: px = 5'd9;
      5'd12: px = 5'd4;
      5'd13: px = 5'd3;
      5'd14: px = 5'd2;
      5'd15: px = 5'd1;
      5'd16: px = 5'd0;
      5'd17: px = 5'd5;
      5'd18: px = 5'd10;
      5'd19: px = 5'd15;
      5'd20: px = 5'd20;
      5'd21: px = 5'd21;
      5'd22: px = 5'd22;
      5'd23: px = 5'd23;
      5'd24: px = 5'd24;
      default: begin
        px  = 5'd0;
        hit = 1'b0;
      end
    endcase
    return hit ? (25'd1 << px) : 25'd0;
  endfunction

  // one-hot pixel for a raw position, zero when off the matrix
  function automatic logic [24:0] pixel_bit(input logic [4:0] pos);
    return (pos < 5'(NumPixels)) ? (25'd1 << pos) : 25'd0;
  endfunction

  // index walk, wraps modulo 32
  function automatic logic [4:0] step_idx(input logic [4:0] pos, input logic down);
    return down ? (pos - 5'd1) : (pos + 5'd1);
  endfunction

endpackage

`default_nettype wire

### rtl/core/led_matrix_animation_engine_unit.sv
// top level of the led matrix animation engine: event decode, animation state, result register
//
// usage
// - input channel (in_valid_i / in_ready_o / in_data_i) carries one event request:
//   frame tick, behaviour command, state query or button stop
// - output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one result
//   request per event: frame bits, dwell time, report word and the loop-running flag
// - an accepted request lands in an input register; once the output register is free it is
//   evaluated by the pattern logic, the animation state updates and the result enters the
//   output register
// - throughput is one request per cycle while the receiver does not stall, set by the single
//   pass of pattern logic between the input register and the output register
// - while the receiver stalls, the held result stays stable and one more request
//   can still be taken into the input register; after that in_ready_o drops
// - reset (rst_ni low) empties both registers, stops the loop, clears the image,
//   sets modes to zero, the flash phase and paint flag to one and dwell to 100 ms
`default_nettype none

module led_matrix_animation_engine_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  lmae_pkg::lmae_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output lmae_pkg::lmae_out_t out_data_o
);
  import lmae_pkg::*;

  // input stage
  logic     in_valid_q;
  lmae_in_t in_data_q;

  // output stage
  logic      out_valid_q;
  lmae_out_t out_data_q, out_data_d;

  // animation state
  logic [7:0]  light_mode_q, light_mode_d;
  logic [7:0]  audio_mode_q, audio_mode_d;
  logic        running_q, running_d;
  logic [24:0] image_q, image_d;
  logic        flash_phase_q, flash_phase_d;
  logic [4:0]  step_pos_q, step_pos_d;
  logic        step_down_q, step_down_d;
  logic        paint_on_q, paint_on_d;
  logic [9:0]  dwell_q, dwell_d;

  logic advance;
  logic in_accept;

  // the result register frees when empty or when its result is taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // spiral and ripple walk intermediate values
  logic [4:0]  spiral_pos1;
  logic        spiral_turn;
  logic [24:0] spiral_bit;
  logic [4:0]  ripple_pos1;

  assign spiral_bit  = coil_bit(step_pos_q);
  assign spiral_pos1 = step_idx(step_pos_q, step_down_q);
  assign spiral_turn = (spiral_pos1 == SpiralTop) || (spiral_pos1 == SpiralBottom);
  assign ripple_pos1 = step_idx(step_pos_q, step_down_q);

  always_comb begin
    logic        fv;
    logic        rv;
    logic [15:0] word;
    light_mode_d  = light_mode_q;
    audio_mode_d  = audio_mode_q;
    running_d     = running_q;
    image_d       = image_q;
    flash_phase_d = flash_phase_q;
    step_pos_d    = step_pos_q;
    step_down_d   = step_down_q;
    paint_on_d    = paint_on_q;
    dwell_d       = dwell_q;
    fv            = 1'b0;
    rv            = 1'b0;
    word          = 16'd0;

    case (in_data_q.action)
      ActTick: begin
        if (running_q) begin
          case (light_mode_q)
            ModeStop: begin
              running_d = 1'b0;
            end
            ModeFlash: begin
              image_d       = flash_phase_q ? AllPixels : 25'd0;
              flash_phase_d = !flash_phase_q;
              fv            = 1'b1;
            end
            ModeRandom: begin
              image_d = flash_phase_q ?
                        (pixel_bit(in_data_q.random_pixel_a) |
                         pixel_bit(in_data_q.random_pixel_b) |
                         pixel_bit(in_data_q.random_pixel_c) |
                         pixel_bit(in_data_q.random_pixel_d)) : 25'd0;
              flash_phase_d = !flash_phase_q;
              fv            = 1'b1;
            end
            ModeRipple: begin
              image_d    = ring_mask(step_pos_q[1:0]);
              step_pos_d = ripple_pos1;
              if ((ripple_pos1 == RippleTop) || (ripple_pos1 == RippleBottom)) begin
                step_down_d = !step_down_q;
              end
              fv = 1'b1;
            end
            ModeSpiral: begin
              // paint or erase one pixel, turn around at either end of the spiral
              image_d    = paint_on_q ? (image_q | spiral_bit) : (image_q & ~spiral_bit);
              step_pos_d = spiral_pos1;
              if (spiral_turn) begin
                step_down_d = !step_down_q;
                step_pos_d  = step_idx(spiral_pos1, !step_down_q);
                paint_on_d  = !paint_on_q;
              end
              fv = 1'b1;
            end
            ModeChecker: begin
              // even and odd pixels alternate: the pattern is fully replaced
              image_d       = flash_phase_q ? EvenPixels : OddPixels;
              flash_phase_d = !flash_phase_q;
              fv            = 1'b1;
            end
            default: begin
              // text and unknown modes hold everything
            end
          endcase
        end
      end
      ActCommand: begin
        if ((in_data_q.light_select != ModeNone) &&
            (in_data_q.light_select != light_mode_q)) begin
          running_d = 1'b1;
          case (in_data_q.light_select)
            ModeRandom: begin
              dwell_d = DwellRandom;
            end
            ModeRipple: begin
              dwell_d     = DwellRipple;
              step_pos_d  = 5'd0;
              step_down_d = 1'b0;
            end
            ModeSpiral: begin
              dwell_d     = DwellSpiral;
              step_pos_d  = 5'd0;
              step_down_d = 1'b0;
              paint_on_d  = 1'b1;
            end
            default: begin
              dwell_d = DwellDefault;
            end
          endcase
        end
        image_d = 25'd0;
        if (in_data_q.audio_select != ModeNone) begin
          audio_mode_d = in_data_q.audio_select;
        end
        if (in_data_q.light_select != ModeNone) begin
          light_mode_d = in_data_q.light_select;
        end
      end
      ActQuery: begin
        rv   = 1'b1;
        word = {audio_mode_q, light_mode_q};
      end
      default: begin
        // button stop: both modes halt, loop flag untouched
        light_mode_d = ModeStop;
        audio_mode_d = ModeStop;
        rv           = 1'b1;
        word         = StopReport;
      end
    endcase

    out_data_d.frame_valid    = fv;
    out_data_d.frame_bits     = image_d;
    out_data_d.dwell_ms       = dwell_d;
    out_data_d.report_valid   = rv;
    out_data_d.report_word    = word;
    out_data_d.display_active = running_d;
  end

  // control and animation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      light_mode_q  <= ModeNone;
      audio_mode_q  <= ModeNone;
      running_q     <= 1'b0;
      image_q       <= 25'd0;
      flash_phase_q <= 1'b1;
      step_pos_q    <= 5'd0;
      step_down_q   <= 1'b0;
      paint_on_q    <= 1'b1;
      dwell_q       <= DwellReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (advance && in_valid_q) begin
        light_mode_q  <= light_mode_d;
        audio_mode_q  <= audio_mode_d;
        running_q     <= running_d;
        image_q       <= image_d;
        flash_phase_q <= flash_phase_d;
        step_pos_q    <= step_pos_d;
        step_down_q   <= step_down_d;
        paint_on_q    <= paint_on_d;
        dwell_q       <= dwell_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/core/lmae_checker.sv
// port-level checker for the led matrix animation engine and its bind
`default_nettype none

module lmae_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input lmae_pkg::lmae_in_t  in_data_i,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input lmae_pkg::lmae_out_t out_data_o
);
  import lmae_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a result is a frame or a report, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.frame_valid && out_data_o.report_valid))
    else $error("frame and report raised together");

  // report word is zero without a report
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.report_valid |-> out_data_o.report_word == 16'd0)
    else $error("report word set without report");

  // a frame is only shown while the loop runs
  a_frame_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_valid |-> out_data_o.display_active)
    else $error("frame shown with loop stopped");

endmodule

bind led_matrix_animation_engine_unit lmae_checker u_lmae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
